>>> rtl/core/mdrc_pkg.sv
// shared types and constants for the memory deny-range checker
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mdrc_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int ADDR_W      = 64;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int FILL_W      = $clog2(NUM_ENTRIES + 1);

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] start_address;
    logic [ADDR_W-1:0] length;
  } req_t;

  typedef struct packed {
    logic    permitted;
    status_t status;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    append;
    logic    scan_clr;
    logic    scan_go;
    logic    res_load;
    logic    res_permitted;
    status_t res_status;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic range_ok;
    logic add_mode;
    logic full;
    logic scan_fin;
    logic hit;
  } dp_stat_t;

endpackage

>>> rtl/core/memory_deny_range_checker.sv
// Memory deny-range checker. One request is worked on at a time; the next
// request can be taken at the first edge at which the previous result can be
// transferred. A check reads the filled entries in order, ending early on the
// first overlapping entry; the table memory is read one entry a cycle and each
// entry is compared in the following cycle. A new request is taken while the
// previous result still waits in the output register, and then holds until
// that result is taken.
// No clearing pass is needed after reset.
// top level: joins mdrc_ctrl and mdrc_dpath; uses mdrc_pkg
`timescale 1ns / 1ps

module memory_deny_range_checker
  import mdrc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mdrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mdrc_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

>>> rtl/core/mdrc_dpath.sv
// datapath: request registers, end address adder, range table memory,
// overlap compare and result register; uses mdrc_pkg
`timescale 1ns / 1ps

module mdrc_dpath
  import mdrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  req_t      in_data,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  output res_t      out_data
);

  logic              mode_r;
  logic [ADDR_W-1:0] lo_r;
  logic [ADDR_W-1:0] hi_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] idx_r;
  logic              pend_r;
  logic              hit_r;
  logic [ADDR_W-1:0] rd_start_r;
  logic [ADDR_W-1:0] rd_end_r;
  res_t              out_r;

  logic [ADDR_W-1:0] start_mem [NUM_ENTRIES];
  logic [ADDR_W-1:0] end_mem   [NUM_ENTRIES];

  logic [ADDR_W-1:0] hi_nxt;
  logic              issue_done;
  logic              overlap;

  // inclusive end, wraps at 64 bits
  assign hi_nxt = in_data.start_address + in_data.length - ADDR_W'(1);

  assign issue_done = (idx_r == fill_r);

  assign overlap = ((rd_start_r <= lo_r) && (lo_r <= rd_end_r)) ||
                   ((rd_start_r <= hi_r) && (hi_r <= rd_end_r)) ||
                   ((lo_r < rd_start_r) && (rd_end_r < hi_r));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_data.mode;
      lo_r   <= in_data.start_address;
      hi_r   <= hi_nxt;
    end
    if (cmd.res_load) begin
      out_r.permitted <= cmd.res_permitted;
      out_r.status    <= cmd.res_status;
    end
  end

  // table memory, written at the fill slot and read one entry a cycle
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      start_mem[fill_r[IDX_W-1:0]] <= lo_r;
      end_mem[fill_r[IDX_W-1:0]]   <= hi_r;
    end
    if (cmd.scan_go && !issue_done) begin
      rd_start_r <= start_mem[idx_r[IDX_W-1:0]];
      rd_end_r   <= end_mem[idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      idx_r  <= '0;
      pend_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      if (cmd.append) begin
        fill_r <= fill_r + FILL_W'(1);
      end
      if (cmd.scan_clr) begin
        idx_r  <= '0;
        pend_r <= 1'b0;
        hit_r  <= 1'b0;
      end else if (cmd.scan_go) begin
        if (!issue_done) begin
          idx_r <= idx_r + FILL_W'(1);
        end
        pend_r <= !issue_done;
        if (pend_r && overlap) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  assign stat.range_ok = (hi_r > lo_r);
  assign stat.add_mode = mode_r;
  assign stat.full     = (fill_r == FILL_W'(NUM_ENTRIES));
  assign stat.scan_fin = hit_r || (issue_done && !pend_r);
  assign stat.hit      = hit_r;

  assign out_data = out_r;

endmodule

>>> rtl/core/mdrc_ctrl.sv
// controller: request sequencing state machine and result handshake
// uses mdrc_pkg; drives the datapath through ctrl_cmd_t
`timescale 1ns / 1ps

module mdrc_ctrl
  import mdrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  // result register may be refilled in the cycle it is taken
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_status = STAT_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!stat.range_ok) begin
          if (slot_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = STAT_INVALID;
            state_nxt      = S_IDLE;
          end
        end else if (stat.add_mode) begin
          if (slot_free) begin
            cmd.res_load   = 1'b1;
            cmd.append     = !stat.full;
            cmd.res_status = stat.full ? STAT_FULL : STAT_OK;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_go = 1'b1;
        if (stat.scan_fin && slot_free) begin
          cmd.res_load      = 1'b1;
          cmd.res_permitted = !stat.hit;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over an untaken transfer");

  a_append_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> (stat.range_ok && !stat.full && stat.add_mode))
    else $error("append of invalid range or into full table");

  a_hit_denies: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && stat.hit && cmd.res_load) |-> !cmd.res_permitted)
    else $error("overlapping check reported as permitted");

endmodule

>>> dv/memory_deny_range_checker_test.sv
// self-checking testbench for memory_deny_range_checker: random and directed
// add/check transfers, predicted deny-table answers compared field by field
// depends on mdrc_pkg and the rtl of memory_deny_range_checker
`timescale 1ns / 1ps

module memory_deny_range_checker_test;
  import mdrc_pkg::*;

  localparam logic MODE_CHECK = 1'b0;
  localparam logic MODE_ADD   = 1'b1;
  localparam logic [63:0] ADDR_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] REGION   = 64'h0000_0040_0000_0000;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 90;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  res_t out_data;

  memory_deny_range_checker u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // mirror of the deny table, updated as requests are accepted
  logic [63:0] deny_lo [NUM_ENTRIES];
  logic [63:0] deny_hi [NUM_ENTRIES];
  int          deny_fill = 0;

  req_t pending_reqs [$];
  res_t answers_due [$];

  int sender_idle_pct = 29;
  int recv_idle_pct   = 57;
  int reqs_taken      = 0;
  int next_hold       = 250;
  int hold_left       = 0;
  int mismatches      = 0;
  int quiet_cycles    = 0;
  logic in_took       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic res_t deny_lookup(req_t r);
    logic [63:0] lo;
    logic [63:0] hi;
    logic        hit;
    res_t        res;
    lo = r.start_address;
    hi = lo + r.length - 64'd1;
    hit = 1'b0;
    res.permitted = 1'b0;
    res.status = STAT_OK;
    if (hi <= lo) begin
      res.status = STAT_INVALID;
    end else if (r.mode == MODE_ADD) begin
      if (deny_fill >= NUM_ENTRIES) begin
        res.status = STAT_FULL;
      end else begin
        deny_lo[deny_fill] = lo;
        deny_hi[deny_fill] = hi;
        deny_fill++;
      end
    end else begin
      for (int i = 0; i < deny_fill; i++) begin
        if ((deny_lo[i] <= lo && lo <= deny_hi[i]) ||
            (deny_lo[i] <= hi && hi <= deny_hi[i]) ||
            (lo < deny_lo[i] && deny_hi[i] < hi))
          hit = 1'b1;
      end
      res.permitted = !hit;
    end
    return res;
  endfunction

  function automatic req_t mk_req(logic mode, logic [63:0] lo, logic [63:0] len);
    req_t r;
    r.mode = mode;
    r.start_address = lo;
    r.length = len;
    return r;
  endfunction

  function automatic req_t make_request();
    req_t        r;
    int          pick;
    int          k;
    logic [63:0] anchor;
    logic [63:0] off;
    pick = $urandom_range(0, 99);
    r.mode = ($urandom_range(0, 99) < 20) ? MODE_ADD : MODE_CHECK;
    if (pick < 8) begin
      // degenerate lengths and addresses near the wrap point
      case ($urandom_range(0, 2))
        0: r.start_address = {$urandom, $urandom};
        1: r.start_address = 64'd0 + $urandom_range(0, 3);
        default: r.start_address = ADDR_MAX - $urandom_range(0, 3);
      endcase
      r.length = $urandom_range(0, 1) ? 64'd0 + $urandom_range(0, 3)
                                      : ADDR_MAX - $urandom_range(0, 3);
    end else if (pick < 20) begin
      r.start_address = {$urandom, $urandom};
      r.length = {$urandom, $urandom};
    end else if (r.mode == MODE_CHECK && deny_fill > 0 && pick < 85) begin
      // land on or just beside an existing entry boundary
      k = $urandom_range(0, deny_fill - 1);
      anchor = $urandom_range(0, 1) ? deny_lo[k] : deny_hi[k];
      off = 64'($urandom_range(0, 8));
      r.start_address = $urandom_range(0, 1) ? anchor + off : anchor - off;
      case ($urandom_range(0, 2))
        0: r.length = 64'($urandom_range(1, 32));
        1: r.length = deny_hi[k] - r.start_address + $urandom_range(0, 8);
        default: r.length = 64'($urandom_range(1, 1 << 20));
      endcase
    end else begin
      r.start_address = REGION + ({32'd0, $urandom_range(0, 255)} << 12)
                        + $urandom_range(0, 4095);
      r.length = {32'd0, $urandom_range(1, 64)} << 12;
    end
    return r;
  endfunction

  // sender: a payload only moves on once the previous transfer went through
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_took) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_data  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls, with a long hold-off every so often
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (reqs_taken >= next_hold) begin
      hold_left <= HOLD_CYCLES;
      next_hold <= next_hold + 700;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // request side: predict every accepted transfer
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      answers_due.push_back(deny_lookup(in_data));
      reqs_taken <= reqs_taken + 1;
    end
  end

  // result side
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: permitted %0b status %0d",
                   out_data.permitted, out_data.status);
      end else begin
        want = answers_due.pop_front();
        if (out_data.permitted !== want.permitted || out_data.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected permitted %0b status %0d, got permitted %0b status %0d",
                     want.permitted, want.status, out_data.permitted, out_data.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("memory_deny_range_checker_test: errors");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || answers_due.size() > 0)
      @(posedge clk);
  endtask

  task automatic feed_random(int n);
    for (int i = 0; i < n; i++) begin
      // keep the queue short so new requests see a current table
      while (pending_reqs.size() >= 4)
        @(posedge clk);
      pending_reqs.push_back(make_request());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table, degenerate ranges
    pending_reqs.push_back(mk_req(MODE_CHECK, 64'h1000, 64'h100));
    pending_reqs.push_back(mk_req(MODE_CHECK, 64'h5000, 64'd0));
    pending_reqs.push_back(mk_req(MODE_CHECK, 64'h5000, 64'd1));
    pending_reqs.push_back(mk_req(MODE_ADD, 64'h5000, 64'd0));
    pending_reqs.push_back(mk_req(MODE_ADD, ADDR_MAX, 64'd1));
    pending_reqs.push_back(mk_req(MODE_CHECK, ADDR_MAX, 64'd2));
    // zero length at address zero wraps to a full-span valid range
    pending_reqs.push_back(mk_req(MODE_CHECK, 64'd0, 64'd0));
    pending_reqs.push_back(mk_req(MODE_ADD, 64'h1000, 64'h1000));
    pending_reqs.push_back(mk_req(MODE_ADD, 64'h8000_0000_0000_0000, 64'h100));
    pending_reqs.push_back(mk_req(MODE_ADD, 64'd0, 64'd2));
    pending_reqs.push_back(mk_req(MODE_ADD, ADDR_MAX - 64'h10, 64'h10));
    // start inside, end inside, entry strictly inside
    pending_reqs.push_back(mk_req(MODE_CHECK, 64'h1800, 64'h1000));
    pending_reqs.push_back(mk_req(MODE_CHECK, 64'h0800, 64'h900));
    pending_reqs.push_back(mk_req(MODE_CHECK, 64'h0f00, 64'h2000));
    // just clear of the neighbours on either side, then spans that overlap entries
    pending_reqs.push_back(mk_req(MODE_CHECK, 64'd2, 64'hffe));
    pending_reqs.push_back(mk_req(MODE_CHECK, 64'h2000, 64'h100));
    pending_reqs.push_back(mk_req(MODE_CHECK, 64'd0, 64'd0));
    pending_reqs.push_back(mk_req(MODE_CHECK, 64'h1fff, 64'd2));
    pending_reqs.push_back(mk_req(MODE_CHECK, ADDR_MAX - 64'h20, 64'h20));
    pending_reqs.push_back(mk_req(MODE_CHECK, 64'd0, ADDR_MAX));
    feed_random(600);
    drain();

    sender_idle_pct = 57;
    recv_idle_pct = 29;
    feed_random(600);
    drain();

    sender_idle_pct = 0;
    recv_idle_pct = 0;
    feed_random(480);
    drain();

    repeat (40) @(posedge clk);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("memory_deny_range_checker_test: clean");
    end else begin
      $display("memory_deny_range_checker_test: errors");
    end
    $finish;
  end

endmodule
